/* src/ifsf_pkg.sv */
// shared types, constants and hash helper functions for the element filter fingerprint
package ifsf_pkg;

    localparam int SALT_BYTES   = 32;
    localparam int DIGEST_BYTES = 32;
    localparam int OUT_WORDS    = (DIGEST_BYTES + 7) / 8;
    localparam int LAST_KEEP    = DIGEST_BYTES - 8 * (OUT_WORDS - 1);

    localparam logic [7:0] TAG_SSID    = 8'd0;
    localparam logic [7:0] TAG_DS      = 8'd3;
    localparam logic [7:0] TAG_COUNTRY = 8'd7;
    localparam logic [7:0] TAG_BSSLOAD = 8'd11;
    localparam logic [7:0] TAG_VENDOR  = 8'd221;

    localparam logic [2:0] REG_SALT_LEN = 3'd0;
    localparam logic [2:0] REG_SALT_W0  = 3'd1;
    localparam logic [2:0] REG_SALT_W3  = 3'd4;

    // control from the parser to the compression unit
    typedef struct packed {
        logic clear;
        logic go;
    } core_ctl_t;

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

/* src/ie_filter_sha256_fingerprint.sv */
// top level: element parser, element store, byte packer and digest output
// A data beat is taken in the idle state and then parsed in the item state; when it completes an
// element the hashed bytes of that element are replayed from the element store, each byte
// through a store read and then a pack, and every filled 64-byte block starts a run of the
// one-round-per-cycle compression unit. The first beat of a frame first packs the salt at one
// cycle per byte. The end-of-frame beat packs the padding at one cycle per byte (held while a
// filled block is compressed) up to the length field, runs one or two compressions, then
// delivers four digest beats, the last with tlast set; s_tready stays low until the last is taken.
module ie_filter_sha256_fingerprint (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // digest_word, word_index, element_count, payload_length, zeros
    output logic        m_tlast,   // last_word
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import ifsf_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SALT = 9'b000000010,
        S_ITEM = 9'b000000100,
        S_DONE = 9'b000001000,
        S_ERD  = 9'b000010000,
        S_EFD  = 9'b000100000,
        S_PAD  = 9'b001000000,
        S_COMP = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    typedef enum logic [1:0] {
        PH_TAG = 2'd0,
        PH_LEN = 2'd1,
        PH_VAL = 2'd2
    } phase_t;

    state_t       state_reg, state_next, ret_reg;
    phase_t       phase_reg;
    logic [5:0]   salt_len_reg;
    logic [63:0]  salt_reg [4];
    logic         salt_mixed_reg;
    logic [5:0]   salt_cnt_reg;
    logic         op_reg;
    logic [7:0]   byte_reg;
    logic [7:0]   tag_reg, len_reg, fill_reg;
    logic [7:0]   count_reg;
    logic [15:0]  bytes_reg;
    logic [63:0]  bitlen_reg, total_reg;
    logic [511:0] blk_reg;
    logic         go_reg;
    logic         stable_reg;
    logic [8:0]   step_reg;
    logic [1:0]   widx_reg;
    logic [7:0]   store_mem [256];
    logic [7:0]   rd_q;

    logic         feed_en;
    logic [7:0]   feed_byte;
    logic [5:0]   pos;
    logic [5:0]   salt_n;
    logic [7:0]   sidx;
    logic [8:0]   step_end;
    logic         is_stable, is_vendor;
    logic [63:0]  salt_word;
    logic [63:0]  out_word;
    logic         core_busy, core_done;
    logic [255:0] core_hash;
    core_ctl_t    ctl;
    logic         in_beat, out_beat;

    assign pos      = bitlen_reg[8:3];
    assign salt_n   = (salt_len_reg > 6'(SALT_BYTES)) ? 6'(SALT_BYTES) : salt_len_reg;
    assign salt_word = salt_reg[salt_cnt_reg[4:3]];
    assign sidx     = stable_reg ? 8'(step_reg - 9'd2) : 8'(step_reg - 9'd1);
    assign step_end = stable_reg ? ({1'b0, len_reg} + 9'd2) : 9'd4;
    assign is_stable = (tag_reg != TAG_SSID) && (tag_reg != TAG_DS) &&
                       (tag_reg != TAG_COUNTRY) && (tag_reg != TAG_BSSLOAD) &&
                       (tag_reg != TAG_VENDOR);
    assign is_vendor = (tag_reg == TAG_VENDOR) && (len_reg >= 8'd3);
    assign in_beat  = s_tvalid & s_tready;
    assign out_beat = m_tvalid & m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // next state and the byte packed this cycle
    always_comb begin
        state_next = state_reg;
        feed_en    = 1'b0;
        feed_byte  = 8'd0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    state_next = salt_mixed_reg ? S_ITEM : S_SALT;
                end
            end
            S_SALT: begin
                if (salt_cnt_reg == salt_n) begin
                    state_next = S_ITEM;
                end else begin
                    feed_en    = 1'b1;
                    feed_byte  = salt_word[63 - 8 * salt_cnt_reg[2:0] -: 8];
                end
            end
            S_ITEM: begin
                if (op_reg) begin
                    feed_en    = 1'b1;
                    feed_byte  = 8'h80;
                    state_next = S_PAD;
                end else begin
                    priority case (phase_reg)
                        PH_LEN:  state_next = (byte_reg == 8'd0) ? S_DONE : S_IDLE;
                        PH_VAL:  state_next = ((fill_reg + 8'd1) >= len_reg) ? S_DONE : S_IDLE;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_DONE: begin
                state_next = (is_stable || is_vendor) ? S_ERD : S_IDLE;
            end
            S_ERD: begin
                state_next = S_EFD;
            end
            S_EFD: begin
                feed_en = 1'b1;
                if (step_reg == 9'd0) begin
                    feed_byte = tag_reg;
                end else if (stable_reg && step_reg == 9'd1) begin
                    feed_byte = len_reg;
                end else begin
                    feed_byte = rd_q;
                end
                state_next = ((step_reg + 9'd1) == step_end) ? S_IDLE : S_ERD;
            end
            S_PAD: begin
                if (pos == 6'd56) begin
                    state_next = S_COMP;
                end else begin
                    feed_en   = 1'b1;
                    feed_byte = 8'd0;
                end
            end
            S_COMP: begin
                if (core_done) begin
                    state_next = ret_reg;
                end
            end
            S_OUT: begin
                if (out_beat && widx_reg == 2'(OUT_WORDS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state, parser and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            phase_reg      <= PH_TAG;
            salt_len_reg   <= '0;
            for (int i = 0; i < 4; i++) begin
                salt_reg[i] <= '0;
            end
            salt_mixed_reg <= 1'b0;
            salt_cnt_reg   <= '0;
            tag_reg        <= '0;
            len_reg        <= '0;
            fill_reg       <= '0;
            count_reg      <= '0;
            bytes_reg      <= '0;
            bitlen_reg     <= '0;
            go_reg         <= 1'b0;
            step_reg       <= '0;
            widx_reg       <= '0;
            stable_reg     <= 1'b0;
        end else begin
            go_reg <= 1'b0;

            // configuration writes
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_SALT_LEN) begin
                    salt_len_reg <= cfg_data[5:0];
                end else if (cfg_index >= REG_SALT_W0 && cfg_index <= REG_SALT_W3) begin
                    salt_reg[2'(cfg_index - REG_SALT_W0)] <= cfg_data;
                end
            end

            if (in_beat && !s_tuser) begin
                bytes_reg <= bytes_reg + 16'd1;
            end

            // byte packing, a full block starts a compression
            if (feed_en) begin
                bitlen_reg <= bitlen_reg + 64'd8;
                if (pos == 6'd63) begin
                    go_reg    <= 1'b1;
                    ret_reg   <= state_next;
                    state_reg <= S_COMP;
                end else begin
                    state_reg <= state_next;
                end
            end else if (state_reg == S_PAD && pos == 6'd56) begin
                go_reg    <= 1'b1;
                ret_reg   <= S_OUT;
                state_reg <= S_COMP;
            end else begin
                state_reg <= state_next;
            end

            unique case (state_reg)
                S_SALT: begin
                    if (salt_cnt_reg == salt_n) begin
                        salt_mixed_reg <= 1'b1;
                    end else begin
                        salt_cnt_reg <= salt_cnt_reg + 6'd1;
                    end
                end
                S_ITEM: begin
                    if (op_reg) begin
                        total_reg <= bitlen_reg;
                    end else begin
                        unique case (phase_reg)
                            PH_TAG: begin
                                tag_reg   <= byte_reg;
                                phase_reg <= PH_LEN;
                            end
                            PH_LEN: begin
                                len_reg   <= byte_reg;
                                fill_reg  <= '0;
                                phase_reg <= (byte_reg == 8'd0) ? PH_TAG : PH_VAL;
                            end
                            default: begin
                                fill_reg <= fill_reg + 8'd1;
                                if ((fill_reg + 8'd1) >= len_reg) begin
                                    phase_reg <= PH_TAG;
                                end
                            end
                        endcase
                    end
                end
                S_DONE: begin
                    stable_reg <= is_stable;
                    step_reg   <= '0;
                    if (is_stable || is_vendor) begin
                        count_reg <= count_reg + 8'd1;
                    end
                end
                S_EFD: begin
                    step_reg <= step_reg + 9'd1;
                end
                S_OUT: begin
                    if (out_beat) begin
                        if (widx_reg == 2'(OUT_WORDS - 1)) begin
                            widx_reg       <= '0;
                            phase_reg      <= PH_TAG;
                            tag_reg        <= '0;
                            len_reg        <= '0;
                            fill_reg       <= '0;
                            count_reg      <= '0;
                            bytes_reg      <= '0;
                            bitlen_reg     <= '0;
                            salt_mixed_reg <= 1'b0;
                            salt_cnt_reg   <= '0;
                        end else begin
                            widx_reg <= widx_reg + 2'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // held input beat and block buffer
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            op_reg   <= s_tuser;
            byte_reg <= s_tdata;
        end
        if (feed_en) begin
            blk_reg[511 - 8 * pos -: 8] <= feed_byte;
        end else if (state_reg == S_PAD && pos == 6'd56) begin
            blk_reg[63:0] <= total_reg;
        end
    end

    // element store
    always_ff @(posedge aclk) begin
        if (state_reg == S_ITEM && !op_reg && phase_reg == PH_VAL) begin
            store_mem[fill_reg] <= byte_reg;
        end
        rd_q <= store_mem[sidx];
    end

    assign ctl.go    = go_reg;
    assign ctl.clear = out_beat && (widx_reg == 2'(OUT_WORDS - 1));

    ifsf_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .block   (blk_reg),
        .busy    (core_busy),
        .done    (core_done),
        .hash    (core_hash)
    );

    // digest beat
    always_comb begin
        out_word = core_hash[255 - 64 * widx_reg -: 64];
        if (LAST_KEEP < 8 && widx_reg == 2'(OUT_WORDS - 1)) begin
            out_word = out_word & ({64{1'b1}} << (8 * (8 - LAST_KEEP)));
        end
    end

    assign m_tvalid = (state_reg == S_OUT);
    assign m_tlast  = (widx_reg == 2'(OUT_WORDS - 1));
    assign m_tdata  = {6'd0, bytes_reg, count_reg, widx_reg, out_word};

    a_go_comp: assert property (@(posedge aclk) disable iff (!aresetn)
        go_reg |-> state_reg == S_COMP)
        else $error("compression start outside wait state");
    a_out_core_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !core_busy)
        else $error("digest shown while compression runs");
    a_pack_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        feed_en |-> !core_busy)
        else $error("block buffer written during compression");

endmodule

/* src/ifsf_core.sv */
// iterative sha-256 compression unit, one round per cycle, holds the chaining value
module ifsf_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  ifsf_pkg::core_ctl_t ctl,
    input  logic [511:0]        block,
    output logic                busy,
    output logic                done,
    output logic [255:0]        hash
);
    import ifsf_pkg::*;

    logic [31:0] hash_reg [8];
    logic [31:0] v_reg    [8];
    logic [31:0] win_reg  [16];
    logic [5:0]  rnd_reg;
    logic        run_reg;
    logic        add_reg;
    logic        done_reg;

    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] mj;

    // round datapath and schedule extension
    always_comb begin
        w_new = win_reg[0] + ssig0(win_reg[1]) + win_reg[9] + ssig1(win_reg[14]);
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        mj    = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1    = v_reg[7] + bsig1(v_reg[4]) + ch + K_TAB[rnd_reg] + win_reg[0];
        t2    = bsig0(v_reg[0]) + mj;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            add_reg  <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            add_reg  <= 1'b0;
            if (ctl.go) begin
                run_reg <= 1'b1;
                rnd_reg <= '0;
            end else if (run_reg) begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    run_reg <= 1'b0;
                    add_reg <= 1'b1;
                end
            end
            if (add_reg) begin
                done_reg <= 1'b1;
            end
        end
    end

    // working variables, schedule window and chaining value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                hash_reg[i] <= H_INIT[i];
            end
        end else begin
            if (ctl.clear) begin
                for (int i = 0; i < 8; i++) begin
                    hash_reg[i] <= H_INIT[i];
                end
            end else if (add_reg) begin
                for (int i = 0; i < 8; i++) begin
                    hash_reg[i] <= hash_reg[i] + v_reg[i];
                end
            end
        end
        if (ctl.go) begin
            for (int i = 0; i < 16; i++) begin
                win_reg[i] <= block[511 - 32 * i -: 32];
            end
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= hash_reg[i];
            end
        end else if (run_reg) begin
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign busy = run_reg | add_reg;
    assign done = done_reg;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            hash[255 - 32 * i -: 32] = hash_reg[i];
        end
    end

    a_go_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.go |-> !run_reg && !add_reg)
        else $error("compression started while busy");
    a_done_after_add: assert property (@(posedge aclk) disable iff (!aresetn)
        add_reg |=> done_reg)
        else $error("done missing after final add");
    a_clear_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.clear |-> !run_reg && !add_reg)
        else $error("chaining value cleared during compression");

endmodule
